### hw/rtl/apcs_pkg.sv
// Shared types and constants for the platform collision scan block.
`timescale 1ns / 1ps

package apcs_pkg;

	localparam int MAX_PLATFORMS = 64;
	localparam int POS_W         = 16;
	localparam int SIZE_W        = 15;
	localparam int HIT_IDX_W     = 6;
	// doubled center plus or minus a full size
	localparam int EDGE_W        = POS_W + 3;
	localparam int IN_DATA_W     = 64;
	localparam int OUT_DATA_W    = 80;

	localparam logic OP_ADD      = 1'b0;
	localparam logic OP_QUERY    = 1'b1;
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0]       h;
		logic [SIZE_W-1:0]       w;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] x;
	} rect_t;

	typedef struct packed {
		logic overlap;
		logic left;
		logic right;
		logic below;
		logic above;
	} hit_t;

	typedef struct packed {
		rect_t                plat;
		logic                 reported;
		logic                 above;
		logic                 below;
		logic                 right;
		logic                 left;
		logic [HIT_IDX_W-1:0] hit_index;
		logic                 overlap_found;
		logic                 status;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

endpackage

### hw/rtl/apcs_hit.sv
// Overlap and side contact test of a player rectangle against one platform.
`timescale 1ns / 1ps

module apcs_hit (
	input  apcs_pkg::rect_t player,
	input  apcs_pkg::rect_t plat,
	output apcs_pkg::hit_t  hit
);

	localparam int EW = apcs_pkg::EDGE_W;
	localparam int PW = apcs_pkg::POS_W;
	localparam int SW = apcs_pkg::SIZE_W;

	logic signed [EW-1:0] jx2, jy2, jw, jh;
	logic signed [EW-1:0] px2, py2, pw, ph;
	logic signed [EW-1:0] jl, jr, jb, jt;
	logic signed [EW-1:0] pl, pr, pb, pt;

	// doubled centers against full sizes keep the halving exact
	assign jx2 = {{(EW-PW-1){player.x[PW-1]}}, player.x, 1'b0};
	assign jy2 = {{(EW-PW-1){player.y[PW-1]}}, player.y, 1'b0};
	assign px2 = {{(EW-PW-1){plat.x[PW-1]}}, plat.x, 1'b0};
	assign py2 = {{(EW-PW-1){plat.y[PW-1]}}, plat.y, 1'b0};
	assign jw  = {{(EW-SW){1'b0}}, player.w};
	assign jh  = {{(EW-SW){1'b0}}, player.h};
	assign pw  = {{(EW-SW){1'b0}}, plat.w};
	assign ph  = {{(EW-SW){1'b0}}, plat.h};

	assign jl = jx2 - jw;
	assign jr = jx2 + jw;
	assign jb = jy2 - jh;
	assign jt = jy2 + jh;
	assign pl = px2 - pw;
	assign pr = px2 + pw;
	assign pb = py2 - ph;
	assign pt = py2 + ph;

	always_comb begin
		hit.overlap = (jr > pl) && (jl < pr) && (jt > pb) && (jb < pt);
		hit.left    = (player.x < plat.x) && (jl < pl) && (player.y < plat.y);
		hit.right   = (player.x > plat.x) && (jr > pr);
		hit.below   = (player.y < plat.y) && (jt > pb);
		hit.above   = (player.y > plat.y) && (jb < pt);
	end

endmodule

### hw/rtl/aabb_platform_collision_scan.sv
// Top level: platform table in a synchronous memory and the query scan sequencer.
`timescale 1ns / 1ps

// An add item writes one platform into the table in the cycle it is accepted, unless
// the table is full, and raises m_tvalid once the result state has loaded the output
// register. A query walks the table through the single read port of the platform
// memory, one entry per cycle in insertion order, and stops at the first strict
// overlap; a miss reads every stored platform, and a query on an empty table goes
// straight to the result state. A result that finds the output register
// still occupied waits until the previous result transfers. One item is in work at a
// time; the input side is ready whenever the block is idle, even while the last
// result still waits in the output register. The table needs no clearing after
// reset: only entries below the fill count are ever read.
module aabb_platform_collision_scan #(
	parameter int MAX_PLATFORMS = apcs_pkg::MAX_PLATFORMS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_x[15:0], pos_y[31:16], size_w[46:32], size_h[61:47], zero fill
	input  logic [apcs_pkg::IN_DATA_W-1:0]   s_tdata,
	// operation
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status[0], overlap_found[1], hit_index[7:2], touched_left[8], touched_right[9],
	// touched_below[10], touched_above[11], platform_reported[12], platform_x[28:13],
	// platform_y[44:29], platform_w[59:45], platform_h[74:60], zero fill
	output logic [apcs_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int CW = $clog2(MAX_PLATFORMS + 1);
	localparam int IW = (MAX_PLATFORMS > 1) ? $clog2(MAX_PLATFORMS) : 1;
	localparam int XW = (IW > apcs_pkg::HIT_IDX_W) ? IW : apcs_pkg::HIT_IDX_W;
	localparam int PW = apcs_pkg::POS_W;
	localparam int SW = apcs_pkg::SIZE_W;

	apcs_pkg::state_t state_q, state_next;
	apcs_pkg::rect_t  store_q [MAX_PLATFORMS];
	apcs_pkg::rect_t  in_rect, player_q, rdata_s1;
	apcs_pkg::hit_t   hit;
	apcs_pkg::res_t   res_q, res_next;

	logic [CW-1:0] count_q, rd_idx_q;
	logic [IW-1:0] idx_s1;
	logic [XW-1:0] idx_wide;
	logic          valid_s1, out_valid_q;
	logic [apcs_pkg::OUT_DATA_W-1:0] data_q;

	logic in_xfer, is_add, full, wr_en, rd_en, out_load, hit_now, scan_end;

	assign in_rect.x = s_tdata[PW-1:0];
	assign in_rect.y = s_tdata[2*PW-1:PW];
	assign in_rect.w = s_tdata[2*PW+SW-1:2*PW];
	assign in_rect.h = s_tdata[2*PW+2*SW-1:2*PW+SW];

	assign in_xfer  = s_tvalid && s_tready;
	assign is_add   = (s_tuser == apcs_pkg::OP_ADD);
	assign full     = (count_q == CW'(MAX_PLATFORMS));
	assign hit_now  = valid_s1 && hit.overlap;
	assign scan_end = valid_s1 && !hit.overlap && (rd_idx_q == count_q);
	assign idx_wide = XW'(idx_s1);

	apcs_hit u_hit (
		.player (player_q),
		.plat   (rdata_s1),
		.hit    (hit)
	);

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			apcs_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (!is_add && count_q != '0) state_next = apcs_pkg::ST_SCAN;
					else state_next = apcs_pkg::ST_RESULT;
				end
			end
			apcs_pkg::ST_SCAN: begin
				if (hit_now || scan_end) state_next = apcs_pkg::ST_RESULT;
			end
			apcs_pkg::ST_RESULT: begin
				if (out_load) state_next = apcs_pkg::ST_IDLE;
			end
			default: state_next = apcs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == apcs_pkg::ST_IDLE);
		wr_en    = in_xfer && is_add && !full;
		rd_en    = (state_q == apcs_pkg::ST_SCAN) && (rd_idx_q < count_q);
		out_load = (state_q == apcs_pkg::ST_RESULT) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= apcs_pkg::ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_next;
			valid_s1 <= rd_en;
			if (wr_en) count_q <= count_q + 1'b1;
			if (in_xfer) rd_idx_q <= '0;
			else if (rd_en) rd_idx_q <= rd_idx_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// platform memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) store_q[count_q[IW-1:0]] <= in_rect;
		if (rd_en) begin
			rdata_s1 <= store_q[rd_idx_q[IW-1:0]];
			idx_s1   <= rd_idx_q[IW-1:0];
		end
	end

	always_comb begin
		res_next = res_q;
		if (in_xfer) begin
			res_next        = '0;
			res_next.status = (is_add && full) ? apcs_pkg::STATUS_FULL : apcs_pkg::STATUS_OK;
		end else if (state_q == apcs_pkg::ST_SCAN && hit_now) begin
			res_next.overlap_found = 1'b1;
			res_next.hit_index     = idx_wide[apcs_pkg::HIT_IDX_W-1:0];
			res_next.left          = hit.left;
			res_next.right         = hit.right;
			res_next.below         = hit.below;
			res_next.above         = hit.above;
			res_next.reported      = hit.left || hit.right || hit.below || hit.above;
			// platform fields only when some side flag is set
			if (hit.left || hit.right || hit.below || hit.above) res_next.plat = rdata_s1;
			else res_next.plat = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) player_q <= in_rect;
		res_q <= res_next;
		if (out_load) begin
			data_q <= {5'b0, res_q.plat.h, res_q.plat.w, res_q.plat.y, res_q.plat.x,
				res_q.reported, res_q.above, res_q.below, res_q.right, res_q.left,
				res_q.hit_index, res_q.overlap_found, res_q.status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = data_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PLATFORMS))
		else $error("platform count beyond table depth");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == apcs_pkg::ST_SCAN |-> count_q != '0)
		else $error("scan started on an empty table");

	a_count_from_add: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(in_xfer && is_add))
		else $error("platform count moved without an add transfer");

	a_load_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == apcs_pkg::ST_RESULT))
		else $error("output loaded outside the result state");

	a_reported_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && data_q[12] |-> data_q[1])
		else $error("platform reported without an overlap");
`endif

endmodule

### verif/apcs_checker.sv
// Checker for the platform collision scan: predicts each result and compares the output stream.
`timescale 1ns / 1ps

module collision_scan_checker
	import apcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    fail_count,
	output int                    pending_count
);

	localparam int RES_BITS  = $bits(res_t);
	localparam int RECT_BITS = $bits(rect_t);

	rect_t       platform_table [MAX_PLATFORMS];
	int unsigned platform_fill;
	res_t        expected_results [$];
	res_t        want_res;
	res_t        got_res;

	// Predict the single result caused by one item and, for an add, update the platform table.
	function automatic res_t predict_scan_result(logic op, rect_t r);
		res_t   res;
		rect_t  p;
		longint jx2, jy2, jw, jh, px2, py2, pw, ph;
		int     i;
		logic   lft, rgt, blw, abv;
		res = '0;
		if (op == OP_ADD) begin
			if (platform_fill >= MAX_PLATFORMS) begin
				res.status = STATUS_FULL;
			end else begin
				platform_table[platform_fill] = r;
				platform_fill++;
			end
			return res;
		end
		res.status = STATUS_OK;
		jx2 = 2 * longint'($signed(r.x));
		jy2 = 2 * longint'($signed(r.y));
		jw  = longint'(r.w);
		jh  = longint'(r.h);
		for (i = 0; i < int'(platform_fill) && !res.overlap_found; i++) begin
			p   = platform_table[i];
			px2 = 2 * longint'($signed(p.x));
			py2 = 2 * longint'($signed(p.y));
			pw  = longint'(p.w);
			ph  = longint'(p.h);
			if (jx2 + jw > px2 - pw && jx2 - jw < px2 + pw &&
					jy2 + jh > py2 - ph && jy2 - jh < py2 + ph) begin
				lft = (jx2 < px2) && (jx2 - jw < px2 - pw) && (jy2 < py2);
				rgt = (jx2 > px2) && (jx2 + jw > px2 + pw);
				blw = (jy2 < py2) && (jy2 + jh > py2 - ph);
				abv = (jy2 > py2) && (jy2 - jh < py2 + ph);
				res.overlap_found = 1'b1;
				res.hit_index     = i[HIT_IDX_W-1:0];
				res.left          = lft;
				res.right         = rgt;
				res.below         = blw;
				res.above         = abv;
				res.reported      = lft | rgt | blw | abv;
				if (res.reported)
					res.plat = p;
			end
		end
		return res;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			platform_fill = 0;
			fail_count    = 0;
			expected_results.delete();
			pending_count <= 0;
		end else begin
			// compare first: a result leaving now belongs to an older transfer
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no pending item");
					fail_count++;
				end else begin
					want_res = expected_results.pop_front();
					got_res  = res_t'(m_tdata[RES_BITS-1:0]);
					check_field("status", longint'(want_res.status),
						longint'(got_res.status));
					check_field("overlap_found", longint'(want_res.overlap_found),
						longint'(got_res.overlap_found));
					check_field("hit_index", longint'(want_res.hit_index),
						longint'(got_res.hit_index));
					check_field("touched_left", longint'(want_res.left),
						longint'(got_res.left));
					check_field("touched_right", longint'(want_res.right),
						longint'(got_res.right));
					check_field("touched_below", longint'(want_res.below),
						longint'(got_res.below));
					check_field("touched_above", longint'(want_res.above),
						longint'(got_res.above));
					check_field("platform_reported", longint'(want_res.reported),
						longint'(got_res.reported));
					check_field("platform_x", longint'($signed(want_res.plat.x)),
						longint'($signed(got_res.plat.x)));
					check_field("platform_y", longint'($signed(want_res.plat.y)),
						longint'($signed(got_res.plat.y)));
					check_field("platform_w", longint'(want_res.plat.w),
						longint'(got_res.plat.w));
					check_field("platform_h", longint'(want_res.plat.h),
						longint'(got_res.plat.h));
					check_field("zero_fill", longint'(0),
						longint'(m_tdata[OUT_DATA_W-1:RES_BITS]));
				end
			end
			if (s_tvalid && s_tready)
				expected_results = {expected_results,
					predict_scan_result(s_tuser, rect_t'(s_tdata[RECT_BITS-1:0]))};
			pending_count <= expected_results.size();
		end
	end

endmodule

### verif/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the platform collision scan.
`timescale 1ns / 1ps

module testbench;
	import apcs_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PER_PHASE = 470;
	localparam int DRAIN_CYCLES = MAX_PLATFORMS + 16;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = OP_ADD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    fail_count;
	int                    pending_count;

	int    send_idle_pct  = 0;
	int    recv_stall_pct = 0;
	int    add_count      = 0;
	int    query_count    = 0;
	int    stall_cycles;
	rect_t placed [$];

	aabb_platform_collision_scan u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	collision_scan_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	function automatic rect_t make_rect(int x, int y, int w, int h);
		rect_t r;
		r.x = x[POS_W-1:0];
		r.y = y[POS_W-1:0];
		r.w = w[SIZE_W-1:0];
		r.h = h[SIZE_W-1:0];
		return r;
	endfunction

	function automatic int clamp_pos(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic rect_t random_rect(bit small_sizes);
		rect_t r;
		r.x = POS_W'($urandom_range(0, 65535));
		r.y = POS_W'($urandom_range(0, 65535));
		if (small_sizes && $urandom_range(0, 15) != 0) begin
			r.w = SIZE_W'($urandom_range(0, 2047));
			r.h = SIZE_W'($urandom_range(0, 2047));
		end else begin
			r.w = SIZE_W'($urandom_range(0, 32767));
			r.h = SIZE_W'($urandom_range(0, 32767));
		end
		return r;
	endfunction

	// Place a small player rectangle around or near a stored platform.
	function automatic rect_t aimed_query();
		rect_t p;
		int    w, h, reach_x, reach_y;
		if (placed.size() == 0)
			return random_rect(1'b1);
		p = placed[$urandom_range(0, placed.size() - 1)];
		w = $urandom_range(0, 1023);
		h = $urandom_range(0, 1023);
		reach_x = (int'(p.w) + w) / 2 + 4;
		reach_y = (int'(p.h) + h) / 2 + 4;
		return make_rect(
			clamp_pos(int'($signed(p.x)) + int'($urandom_range(0, 2 * reach_x)) - reach_x),
			clamp_pos(int'($signed(p.y)) + int'($urandom_range(0, 2 * reach_y)) - reach_y),
			w, h);
	endfunction

	task automatic send_item(logic op, rect_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_DATA_W - $bits(rect_t)){1'b0}}, r};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (op == OP_ADD) begin
			add_count++;
			if (placed.size() < MAX_PLATFORMS)
				placed = {placed, r};
		end else begin
			query_count++;
		end
	endtask

	// Hold the sender until every pending result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_item(OP_QUERY, random_rect(1'b0));                 // empty table
		send_item(OP_ADD,   make_rect(0, 0, 320, 160));
		send_item(OP_QUERY, make_rect(0, 0, 16, 16));           // equal centers
		send_item(OP_QUERY, make_rect(-100, -20, 200, 64));     // from the left
		send_item(OP_QUERY, make_rect(100, 0, 200, 16));        // from the right
		send_item(OP_QUERY, make_rect(0, 50, 16, 64));          // above
		send_item(OP_QUERY, make_rect(0, -50, 16, 64));         // below
		send_item(OP_QUERY, make_rect(168, 0, 16, 16));         // edges just touch
		send_item(OP_QUERY, make_rect(0, 0, 0, 0));             // zero-size player
		send_item(OP_ADD,   make_rect(1000, 1000, 0, 0));       // zero-size platform
		send_item(OP_QUERY, make_rect(1000, 1000, 32, 32));
		send_item(OP_QUERY, make_rect(1001, 1000, 4, 4));
		send_item(OP_QUERY, make_rect(999, 1001, 4, 4));
		send_item(OP_ADD,   make_rect(32767, -32768, 32767, 0));
		send_item(OP_ADD,   make_rect(-32768, 32767, 0, 32767));
		send_item(OP_QUERY, make_rect(32767, -32768, 32767, 32767));
		send_item(OP_QUERY, make_rect(-32768, 32767, 0, 0));
		send_item(OP_QUERY, make_rect(-32768, -32768, 32767, 32767));
		send_item(OP_QUERY, make_rect(32767, 32767, 32767, 32767));
		send_item(OP_QUERY, make_rect(-32760, 32000, 64, 64));
	endtask

	task automatic run_random(int n_items);
		int k;
		for (k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < 25)
				send_item(OP_ADD, random_rect(1'b1));
			else if ($urandom_range(0, 99) < 70)
				send_item(OP_QUERY, aimed_query());
			else
				send_item(OP_QUERY, random_rect(1'b0));
		end
	endtask

	// End the run when no transfer happens for too long.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_drained();

		send_idle_pct = 0;  recv_stall_pct = 0;
		run_random(RANDOM_PER_PHASE);
		wait_drained();
		send_idle_pct = 55; recv_stall_pct = 0;
		run_random(RANDOM_PER_PHASE);
		wait_drained();
		send_idle_pct = 0;  recv_stall_pct = 55;
		run_random(RANDOM_PER_PHASE);
		wait_drained();
		send_idle_pct = 35; recv_stall_pct = 35;
		run_random(RANDOM_PER_PHASE);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d adds (%0d stored, rest refused) and %0d queries",
			add_count, placed.size(), query_count);
		$display("over four pacing phases of sender gaps and receiver stalls");
		if (fail_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
hw/rtl/apcs_pkg.sv
hw/rtl/apcs_hit.sv
hw/rtl/aabb_platform_collision_scan.sv
verif/apcs_checker.sv
verif/testbench.sv
